// ----- hdl/pgm_pkg.sv -----
// ----------------------------------------------------------------------------
// pgm_pkg - shared types and constants
// Configuration word layout, register indexes, datapath command bundle and
// the reciprocal used for the divide by one hundred.
// ----------------------------------------------------------------------------
package pgm_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME     = 4'd0,
      CSR_WIDE_WIRE  = 4'd1,
      CSR_SHIFT_BITS = 4'd2,
      CSR_SLOT_COUNT = 4'd3
   } pgm_csr_idx_type;

   localparam logic [6:0] VOLUME_RESET     = 7'd100;
   localparam logic       WIDE_WIRE_RESET  = 1'b1;
   localparam logic [4:0] SHIFT_BITS_RESET = 5'd16;
   localparam logic [1:0] SLOT_COUNT_RESET = 2'd2;

   // floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for every x below 2**25
   localparam int          DIV_SHIFT = 32;
   localparam int          QUOT_W    = 19;
   localparam logic [25:0] DIV_RECIP = 26'd42949673;

   localparam logic [QUOT_W-1:0] POS_LIMIT = 19'd32767;
   localparam logic [QUOT_W-1:0] NEG_LIMIT = 19'd32768;
   localparam logic [15:0]       POS_MAG   = 16'd32767;
   localparam logic [15:0]       NEG_MAG   = 16'd32768;

   typedef struct packed {
      logic [6:0] volume;
      logic       wide_wire;
      logic [4:0] shift_bits;
      logic [1:0] slot_count;
   } pgm_cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic clamp;
      logic square;
      logic accum;
      logic fold;
   } pgm_cmd_type;

endpackage

// ----- hdl/pgm_ifs.sv -----
// ----------------------------------------------------------------------------
// pgm_ifs - channel interfaces
// Sample input, wire word output and register write channels.
// ----------------------------------------------------------------------------
interface pgm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               period_last;

   modport source (output valid, sample, period_last, input ready);
   modport sink   (input valid, sample, period_last, output ready);
endinterface

interface pgm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] wire_value;
   logic               slot_index;
   logic               slot_last;
   logic               clipped;
   logic               period_end;
   logic [15:0]        period_peak;
   logic [47:0]        period_energy;
   logic               period_silent;
   logic [31:0]        clip_total;
   logic [31:0]        silent_periods_total;
   logic [15:0]        peak_hold;
   logic [59:0]        energy_total;

   modport source (output valid, wire_value, slot_index, slot_last, clipped, period_end,
                   period_peak, period_energy, period_silent, clip_total,
                   silent_periods_total, peak_hold, energy_total, input ready);
   modport sink   (input valid, wire_value, slot_index, slot_last, clipped, period_end,
                   period_peak, period_energy, period_silent, clip_total,
                   silent_periods_total, peak_hold, energy_total, output ready);
endinterface

interface pgm_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/playback_gain_wire_format_meter.sv -----
// ----------------------------------------------------------------------------
// playback_gain_wire_format_meter - PCM volume, wire formatting and level meter
// A sample is accepted only while the controller is idle, then passes through
// the multiply, reciprocal divide, clamp, square and accumulate steps of the
// shared datapath; slot words leave one per cycle while rsp is ready, from the
// output register, while the next sample is worked on.
// Reset (synchronous): registers to defaults, meter totals cleared.
// ----------------------------------------------------------------------------
module playback_gain_wire_format_meter import pgm_pkg::*; #(
   parameter int MAX_SLOTS = 2
) (
   input  logic       clock,
   input  logic       reset,
   pgm_req_if.sink    req_if,
   pgm_rsp_if.source  rsp_if,
   pgm_csr_if.sink    csr_if
);

   pgm_cfg_type cfg;
   pgm_cmd_type cmd;

   pgm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   pgm_ctrl #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .slot_count (cfg.slot_count),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .slot_index (rsp_if.slot_index),
      .slot_last  (rsp_if.slot_last),
      .cmd        (cmd)
   );

   pgm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .in_sample         (req_if.sample),
      .in_period_last    (req_if.period_last),
      .out_wire_value    (rsp_if.wire_value),
      .out_clipped       (rsp_if.clipped),
      .out_period_end    (rsp_if.period_end),
      .out_period_peak   (rsp_if.period_peak),
      .out_period_energy (rsp_if.period_energy),
      .out_period_silent (rsp_if.period_silent),
      .out_clip_total    (rsp_if.clip_total),
      .out_silent_total  (rsp_if.silent_periods_total),
      .out_peak_hold     (rsp_if.peak_hold),
      .out_energy_total  (rsp_if.energy_total)
   );

endmodule

// ----- hdl/pgm_csr.sv -----
// ----------------------------------------------------------------------------
// pgm_csr - configuration registers
// Volume, wire mode, shift and slot count, written through the csr channel.
// ----------------------------------------------------------------------------
module pgm_csr import pgm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pgm_csr_if.sink     csr_if,
   output pgm_cfg_type cfg
);

   pgm_cfg_type cfg_ff;
   pgm_cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_VOLUME:     cfg_in.volume     = csr_if.data[6:0];
            CSR_WIDE_WIRE:  cfg_in.wide_wire  = csr_if.data[0];
            CSR_SHIFT_BITS: cfg_in.shift_bits = csr_if.data[4:0];
            CSR_SLOT_COUNT: cfg_in.slot_count = csr_if.data[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume     <= VOLUME_RESET;
         cfg_ff.wide_wire  <= WIDE_WIRE_RESET;
         cfg_ff.shift_bits <= SHIFT_BITS_RESET;
         cfg_ff.slot_count <= SLOT_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/pgm_dp.sv -----
// ----------------------------------------------------------------------------
// pgm_dp - gain, wire format and meter datapath
// Scale, divide by reciprocal, clamp, square and shift, then level statistics
// and the output word register.
// ----------------------------------------------------------------------------
module pgm_dp import pgm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pgm_cmd_type        cmd,
   input  pgm_cfg_type        cfg,
   input  logic signed [15:0] in_sample,
   input  logic               in_period_last,
   output logic signed [31:0] out_wire_value,
   output logic               out_clipped,
   output logic               out_period_end,
   output logic [15:0]        out_period_peak,
   output logic [47:0]        out_period_energy,
   output logic               out_period_silent,
   output logic [31:0]        out_clip_total,
   output logic [31:0]        out_silent_total,
   output logic [15:0]        out_peak_hold,
   output logic [59:0]        out_energy_total
);

   // operand and stage registers
   logic signed [15:0]  sample_ff;
   logic                last_ff;
   logic signed [25:0]  prod_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic                neg_ff;
   logic signed [15:0]  clamped_ff;
   logic [15:0]         mag_ff;
   logic                clip_ff;
   logic [30:0]         sq_ff;
   logic signed [31:0]  wire_ff;

   // meter state
   logic [15:0] cur_peak_ff;
   logic [47:0] cur_energy_ff;
   logic        cur_silent_ff;
   logic [15:0] peak_max_ff;
   logic [31:0] clip_count_ff;
   logic [31:0] silent_count_ff;
   logic [59:0] energy_sum_ff;

   // output word
   logic signed [31:0] o_wire_ff;
   logic               o_clip_ff;
   logic               o_end_ff;
   logic [15:0]        o_peak_ff;
   logic [47:0]        o_energy_ff;
   logic               o_silent_ff;
   logic [31:0]        o_clip_total_ff;
   logic [31:0]        o_silent_total_ff;
   logic [15:0]        o_peak_hold_ff;
   logic [59:0]        o_energy_total_ff;

   logic signed [7:0]  vol_s;
   logic signed [23:0] vol_prod;
   logic signed [25:0] prod_in;
   logic [24:0]        abs_x;
   logic [50:0]        recip_prod;
   logic               clip_in;
   logic [15:0]        mag_in;
   logic signed [15:0] clamped_in;
   logic [31:0]        sq_full;
   logic signed [47:0] shifted;
   logic signed [31:0] wire_in;
   logic [15:0]        peak_in;
   logic [48:0]        energy_add;
   logic [47:0]        energy_in;
   logic [31:0]        clip_count_in;
   logic [59:0]        energy_sum_in;
   logic [31:0]        silent_count_in;
   logic [15:0]        peak_max_in;

   assign vol_s    = signed'({1'b0, cfg.volume});
   assign vol_prod = sample_ff * vol_s;
   assign prod_in  = cfg.wide_wire ? {vol_prod, 2'b00} : {{2{vol_prod[23]}}, vol_prod};

   assign abs_x      = prod_ff[25] ? 25'(-prod_ff) : prod_ff[24:0];
   assign recip_prod = abs_x * DIV_RECIP;

   always_comb begin
      if (neg_ff) begin
         clip_in    = quot_ff > NEG_LIMIT;
         mag_in     = clip_in ? NEG_MAG : quot_ff[15:0];
         clamped_in = signed'(16'(16'd0 - mag_in));
      end else begin
         clip_in    = quot_ff > POS_LIMIT;
         mag_in     = clip_in ? POS_MAG : quot_ff[15:0];
         clamped_in = signed'(mag_in);
      end
   end

   assign sq_full = mag_ff * mag_ff;
   assign shifted = 48'(clamped_ff) <<< cfg.shift_bits;

   always_comb begin
      if (!cfg.wide_wire) begin
         wire_in = 32'(clamped_ff);
      end else if (!shifted[47] && (|shifted[46:31])) begin
         wire_in = 32'sh7FFF_FFFF;
      end else if (shifted[47] && !(&shifted[46:31])) begin
         wire_in = 32'sh8000_0000;
      end else begin
         wire_in = shifted[31:0];
      end
   end

   assign peak_in         = (mag_ff > cur_peak_ff) ? mag_ff : cur_peak_ff;
   assign energy_add      = {1'b0, cur_energy_ff} + 49'(sq_ff);
   assign energy_in       = energy_add[48] ? {48{1'b1}} : energy_add[47:0];
   assign clip_count_in   = clip_count_ff + 32'(clip_ff);
   assign energy_sum_in   = energy_sum_ff + 60'(cur_energy_ff);
   assign silent_count_in = silent_count_ff + 32'(cur_silent_ff);
   assign peak_max_in     = (cur_peak_ff > peak_max_ff) ? cur_peak_ff : peak_max_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= in_sample;
         last_ff   <= in_period_last;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.div) begin
         quot_ff <= recip_prod[DIV_SHIFT +: QUOT_W];
         neg_ff  <= prod_ff[25];
      end
      if (cmd.clamp) begin
         clip_ff    <= clip_in;
         mag_ff     <= mag_in;
         clamped_ff <= clamped_in;
      end
      if (cmd.square) begin
         sq_ff   <= sq_full[30:0];
         wire_ff <= wire_in;
      end
      if (cmd.fold) begin
         o_wire_ff       <= wire_ff;
         o_clip_ff       <= clip_ff;
         o_end_ff        <= last_ff;
         o_clip_total_ff <= clip_count_ff;
         if (last_ff) begin
            o_peak_ff         <= cur_peak_ff;
            o_energy_ff       <= cur_energy_ff;
            o_silent_ff       <= cur_silent_ff;
            o_silent_total_ff <= silent_count_in;
            o_peak_hold_ff    <= peak_max_in;
            o_energy_total_ff <= energy_sum_in;
         end else begin
            o_peak_ff         <= '0;
            o_energy_ff       <= '0;
            o_silent_ff       <= 1'b0;
            o_silent_total_ff <= silent_count_ff;
            o_peak_hold_ff    <= peak_max_ff;
            o_energy_total_ff <= energy_sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_peak_ff     <= '0;
         cur_energy_ff   <= '0;
         cur_silent_ff   <= 1'b1;
         peak_max_ff     <= '0;
         clip_count_ff   <= '0;
         silent_count_ff <= '0;
         energy_sum_ff   <= '0;
      end else if (cmd.accum) begin
         cur_peak_ff   <= peak_in;
         cur_energy_ff <= energy_in;
         cur_silent_ff <= cur_silent_ff & (clamped_ff == 16'sd0);
         clip_count_ff <= clip_count_in;
      end else if (cmd.fold && last_ff) begin
         energy_sum_ff   <= energy_sum_in;
         silent_count_ff <= silent_count_in;
         peak_max_ff     <= peak_max_in;
         cur_peak_ff     <= '0;
         cur_energy_ff   <= '0;
         cur_silent_ff   <= 1'b1;
      end
   end

   assign out_wire_value    = o_wire_ff;
   assign out_clipped       = o_clip_ff;
   assign out_period_end    = o_end_ff;
   assign out_period_peak   = o_peak_ff;
   assign out_period_energy = o_energy_ff;
   assign out_period_silent = o_silent_ff;
   assign out_clip_total    = o_clip_total_ff;
   assign out_silent_total  = o_silent_total_ff;
   assign out_peak_hold     = o_peak_hold_ff;
   assign out_energy_total  = o_energy_total_ff;

endmodule

// ----- hdl/pgm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pgm_ctrl - sequencing controller
// Steps one sample through the datapath and repeats the finished word over
// the wire slots.
// ----------------------------------------------------------------------------
module pgm_ctrl import pgm_pkg::*; #(
   parameter int MAX_SLOTS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  slot_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        slot_index,
   output logic        slot_last,
   output pgm_cmd_type cmd
);

   localparam int         SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [3:0] MAX_SLOTS_W = 4'(MAX_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_SQUARE,
      ST_ACCUM,
      ST_FOLD
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic              busy_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] lim_ff;
   logic [3:0]        slots_eff;
   logic [3:0]        lim_wide;
   logic              accept;
   logic              rsp_fire;
   logic              fold_go;

   always_comb begin
      if (slot_count == 2'd0) begin
         slots_eff = 4'd1;
      end else if ({2'b00, slot_count} > MAX_SLOTS_W) begin
         slots_eff = MAX_SLOTS_W;
      end else begin
         slots_eff = {2'b00, slot_count};
      end
   end
   assign lim_wide = slots_eff - 4'd1;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = busy_ff;
   assign rsp_fire   = busy_ff && rsp_ready;
   assign slot_index = slot_ff[0];
   assign slot_last  = (slot_ff == lim_ff);
   assign fold_go    = (state_ff == ST_FOLD) && !busy_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      cmd.mul    = (state_ff == ST_MUL);
      cmd.div    = (state_ff == ST_DIV);
      cmd.clamp  = (state_ff == ST_CLAMP);
      cmd.square = (state_ff == ST_SQUARE);
      cmd.accum  = (state_ff == ST_ACCUM);
      cmd.fold   = fold_go;
   end

   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = accept ? ST_MUL : ST_IDLE;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_FOLD;
         ST_FOLD:   state_in = fold_go ? ST_IDLE : ST_FOLD;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         slot_ff  <= '0;
         lim_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (fold_go) begin
            busy_ff <= 1'b1;
            slot_ff <= '0;
            lim_ff  <= lim_wide[SLOT_W-1:0];
         end else if (rsp_fire) begin
            if (slot_ff == lim_ff) begin
               busy_ff <= 1'b0;
            end else begin
               slot_ff <= slot_ff + SLOT_W'(1);
            end
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> slot_ff <= lim_ff)
      else $error("slot counter beyond slot limit");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL)
      else $error("accepted sample did not start the multiply step");

   a_fold_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD && busy_ff) |=> state_ff == ST_FOLD)
      else $error("fold left while output word still pending");

   a_last_slot_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && slot_ff == lim_ff) |=> !busy_ff)
      else $error("output still busy after last slot word");
`endif

endmodule
